// ===== rtl/crom_pkg.sv =====
package crom_pkg;

	localparam int DEF_VALUE_WIDTH = 32;
	localparam int DEF_T_FRAC_BITS = 16;

	localparam int NUM_TAPS = 4;

	localparam int W_GUARD_BITS = 5;
	localparam int ACC_GUARD_BITS = 2;

endpackage

// ===== rtl/catmull_rom_interpolator.sv =====
// Channel   Direction  Handshake                 Payload
// command   in         start (busy is always 0)  t_param, ctrl_before, ctrl_start,
//                                                ctrl_end, ctrl_after
// result    out        done, one-cycle strobe    interp_value, overflow
//
// One transaction may enter every cycle; each result passes through eight register
// stages in order: square, cube, weights, partial products, lane sums, pair sums,
// total, round and saturate.
// Reset clears only the valid bits; data registers hold whatever they last saw.
// Nothing inside stalls: results leave on done whether or not anyone looks.
module catmull_rom_interpolator #(
	parameter int VALUE_WIDTH = crom_pkg::DEF_VALUE_WIDTH,
	parameter int T_FRAC_BITS = crom_pkg::DEF_T_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic        [T_FRAC_BITS:0]   t_param,
	input  logic signed [VALUE_WIDTH-1:0] ctrl_before,
	input  logic signed [VALUE_WIDTH-1:0] ctrl_start,
	input  logic signed [VALUE_WIDTH-1:0] ctrl_end,
	input  logic signed [VALUE_WIDTH-1:0] ctrl_after,
	output logic                          done,
	output logic signed [VALUE_WIDTH-1:0] interp_value,
	output logic                          overflow
);
	import crom_pkg::*;

	localparam int W_WIDTH   = T_FRAC_BITS + W_GUARD_BITS;
	localparam int ACC_WIDTH = VALUE_WIDTH + W_WIDTH + ACC_GUARD_BITS;
	localparam int LATENCY   = 8;
	localparam logic signed [VALUE_WIDTH-1:0] V_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic signed [VALUE_WIDTH-1:0] V_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	logic                          accept;
	logic signed [VALUE_WIDTH-1:0] ctrl_in [NUM_TAPS];
	logic                          valid_s3, valid_s7;
	logic signed [W_WIDTH-1:0]     w_s3 [NUM_TAPS];
	logic signed [VALUE_WIDTH-1:0] ctrl_s3 [NUM_TAPS];
	logic signed [ACC_WIDTH-1:0]   acc_s7;

	assign busy    = 1'b0;
	assign accept  = start & ~busy;
	assign ctrl_in = '{ctrl_before, ctrl_start, ctrl_end, ctrl_after};

	crom_basis #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.T_FRAC_BITS(T_FRAC_BITS),
		.W_WIDTH    (W_WIDTH)
	) u_basis (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(accept),
		.t_param (t_param),
		.ctrl    (ctrl_in),
		.valid_s3(valid_s3),
		.w_s3    (w_s3),
		.ctrl_s3 (ctrl_s3)
	);

	crom_mac #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.T_FRAC_BITS(T_FRAC_BITS),
		.W_WIDTH    (W_WIDTH),
		.ACC_WIDTH  (ACC_WIDTH)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_s3(valid_s3),
		.w_s3    (w_s3),
		.ctrl_s3 (ctrl_s3),
		.valid_s7(valid_s7),
		.acc_s7  (acc_s7)
	);

	crom_sat #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.T_FRAC_BITS(T_FRAC_BITS),
		.ACC_WIDTH  (ACC_WIDTH)
	) u_sat (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_s7(valid_s7),
		.acc_s7  (acc_s7),
		.valid_s8(done),
		.value_s8(interp_value),
		.ovf_s8  (overflow)
	);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("result strobe missing after accepted transaction");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("result strobe without matching transaction");

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(done && overflow) |-> (interp_value == V_MAX || interp_value == V_MIN))
		else $error("saturated result not at a bound");

	a_t_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && t_param == '0) |->
			##LATENCY (interp_value == $past(ctrl_start, LATENCY) && !overflow))
		else $error("t of zero must return the segment start");

endmodule

// ===== rtl/crom_basis.sv =====
module crom_basis #(
	parameter int VALUE_WIDTH = crom_pkg::DEF_VALUE_WIDTH,
	parameter int T_FRAC_BITS = crom_pkg::DEF_T_FRAC_BITS,
	parameter int W_WIDTH     = crom_pkg::DEF_T_FRAC_BITS + crom_pkg::W_GUARD_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic        [T_FRAC_BITS:0]   t_param,
	input  logic signed [VALUE_WIDTH-1:0] ctrl [crom_pkg::NUM_TAPS],
	output logic                          valid_s3,
	output logic signed [W_WIDTH-1:0]     w_s3 [crom_pkg::NUM_TAPS],
	output logic signed [VALUE_WIDTH-1:0] ctrl_s3 [crom_pkg::NUM_TAPS]
);
	import crom_pkg::*;

	localparam int TW = T_FRAC_BITS + 1;
	localparam int PW = 2 * TW;
	localparam logic [TW-1:0] T_ONE  = {1'b1, {T_FRAC_BITS{1'b0}}};
	localparam logic [PW-1:0] T_HALF = PW'(1) << (T_FRAC_BITS - 1);

	logic        [TW-1:0]          t_clamp;
	logic        [PW-1:0]          sq;
	logic        [PW-1:0]          cu;
	logic                          valid_s1, valid_s2;
	logic        [TW-1:0]          t_s1, t2_s1;
	logic        [TW-1:0]          t_s2, t2_s2, t3_s2;
	logic signed [VALUE_WIDTH-1:0] ctrl_s1 [NUM_TAPS];
	logic signed [VALUE_WIDTH-1:0] ctrl_s2 [NUM_TAPS];
	logic signed [W_WIDTH-1:0]     e_t, e_t2, e_t3, e_one;

	// stage 1: clamp t and square it
	assign t_clamp = (t_param > T_ONE) ? T_ONE : t_param;
	assign sq      = PW'(t_clamp) * PW'(t_clamp) + T_HALF;

	// stage 2: cube
	assign cu = PW'(t2_s1) * PW'(t_s1) + T_HALF;

	// stage 3: doubled basis weights
	assign e_t   = $signed(W_WIDTH'(t_s2));
	assign e_t2  = $signed(W_WIDTH'(t2_s2));
	assign e_t3  = $signed(W_WIDTH'(t3_s2));
	assign e_one = $signed(W_WIDTH'(T_ONE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		t_s1    <= t_clamp;
		t2_s1   <= sq[T_FRAC_BITS +: TW];
		ctrl_s1 <= ctrl;

		t_s2    <= t_s1;
		t2_s2   <= t2_s1;
		t3_s2   <= cu[T_FRAC_BITS +: TW];
		ctrl_s2 <= ctrl_s1;

		w_s3[0] <= (e_t2 <<< 1) - e_t3 - e_t;
		w_s3[1] <= (e_t3 <<< 1) + e_t3 - (e_t2 <<< 2) - e_t2 + (e_one <<< 1);
		w_s3[2] <= (e_t2 <<< 2) + e_t - (e_t3 <<< 1) - e_t3;
		w_s3[3] <= e_t3 - e_t2;
		ctrl_s3 <= ctrl_s2;
	end

endmodule

// ===== rtl/crom_mac.sv =====
module crom_mac #(
	parameter int VALUE_WIDTH = crom_pkg::DEF_VALUE_WIDTH,
	parameter int T_FRAC_BITS = crom_pkg::DEF_T_FRAC_BITS,
	parameter int W_WIDTH     = crom_pkg::DEF_T_FRAC_BITS + crom_pkg::W_GUARD_BITS,
	parameter int ACC_WIDTH   = crom_pkg::DEF_VALUE_WIDTH + crom_pkg::DEF_T_FRAC_BITS
		+ crom_pkg::W_GUARD_BITS + crom_pkg::ACC_GUARD_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_s3,
	input  logic signed [W_WIDTH-1:0]     w_s3 [crom_pkg::NUM_TAPS],
	input  logic signed [VALUE_WIDTH-1:0] ctrl_s3 [crom_pkg::NUM_TAPS],
	output logic                          valid_s7,
	output logic signed [ACC_WIDTH-1:0]   acc_s7
);
	import crom_pkg::*;

	localparam int LO_W   = VALUE_WIDTH / 2;
	localparam int HI_W   = VALUE_WIDTH - LO_W;
	localparam int PROD_W = VALUE_WIDTH + W_WIDTH;
	localparam logic signed [ACC_WIDTH-1:0] RND = ACC_WIDTH'(1) <<< T_FRAC_BITS;

	logic signed [LO_W:0]              lo_op [NUM_TAPS];
	logic signed [HI_W-1:0]            hi_op [NUM_TAPS];
	logic signed [LO_W+W_WIDTH:0]      lo_s4 [NUM_TAPS];
	logic signed [HI_W+W_WIDTH-1:0]    hi_s4 [NUM_TAPS];
	logic signed [PROD_W-1:0]          lane_s5 [NUM_TAPS];
	logic signed [ACC_WIDTH-1:0]       pair_s6 [2];
	logic                              valid_s4, valid_s5, valid_s6;

	// split each control value so every multiplier stays narrow
	always_comb begin
		for (int k = 0; k < NUM_TAPS; k++) begin
			lo_op[k] = {1'b0, ctrl_s3[k][LO_W-1:0]};
			hi_op[k] = ctrl_s3[k][VALUE_WIDTH-1:LO_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_TAPS; k++) begin
			lo_s4[k]   <= lo_op[k] * w_s3[k];
			hi_s4[k]   <= hi_op[k] * w_s3[k];
			lane_s5[k] <= (PROD_W'(hi_s4[k]) <<< LO_W) + PROD_W'(lo_s4[k]);
		end
		pair_s6[0] <= ACC_WIDTH'(lane_s5[0]) + ACC_WIDTH'(lane_s5[1]);
		pair_s6[1] <= ACC_WIDTH'(lane_s5[2]) + ACC_WIDTH'(lane_s5[3]) + RND;
		acc_s7     <= pair_s6[0] + pair_s6[1];
	end

endmodule

// ===== rtl/crom_sat.sv =====
module crom_sat #(
	parameter int VALUE_WIDTH = crom_pkg::DEF_VALUE_WIDTH,
	parameter int T_FRAC_BITS = crom_pkg::DEF_T_FRAC_BITS,
	parameter int ACC_WIDTH   = crom_pkg::DEF_VALUE_WIDTH + crom_pkg::DEF_T_FRAC_BITS
		+ crom_pkg::W_GUARD_BITS + crom_pkg::ACC_GUARD_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_s7,
	input  logic signed [ACC_WIDTH-1:0]   acc_s7,
	output logic                          valid_s8,
	output logic signed [VALUE_WIDTH-1:0] value_s8,
	output logic                          ovf_s8
);
	localparam int SH_W = ACC_WIDTH - T_FRAC_BITS - 1;
	localparam logic [VALUE_WIDTH-1:0] V_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic [VALUE_WIDTH-1:0] V_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	logic [SH_W-1:0]          sh;
	logic [SH_W-VALUE_WIDTH:0] upper;
	logic                     fits;

	// drop the fraction; the rounding bias is already in the sum
	assign sh    = acc_s7[ACC_WIDTH-1:T_FRAC_BITS+1];
	assign upper = sh[SH_W-1:VALUE_WIDTH-1];
	assign fits  = (&upper) | ~(|upper);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else begin
			valid_s8 <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		ovf_s8 <= ~fits;
		if (fits) begin
			value_s8 <= sh[VALUE_WIDTH-1:0];
		end else if (sh[SH_W-1]) begin
			value_s8 <= V_MIN;
		end else begin
			value_s8 <= V_MAX;
		end
	end

endmodule

// ===== tb/tb_catmull_rom_interpolator.sv =====
`timescale 1ns / 100ps

module tb_catmull_rom_interpolator;

	localparam int VW = crom_pkg::DEF_VALUE_WIDTH;
	localparam int TF = crom_pkg::DEF_T_FRAC_BITS;
	localparam int AW = 128;
	localparam int LATENCY = 8;
	localparam int RANDOM_PER_PHASE = 160;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PRINT_LIMIT = 100;

	localparam logic [TF:0] T_ONE = {1'b1, {TF{1'b0}}};
	localparam logic signed [VW-1:0] V_MAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] V_MIN = {1'b1, {(VW-1){1'b0}}};
	localparam logic signed [VW-1:0] Q_ONE = VW'(1) << 16;

	typedef enum int {CTRL_SMALL, CTRL_FULL, CTRL_EXTREME, CTRL_NEAR_LIMIT} ctrl_mode_t;

	typedef struct packed {
		logic [TF:0]          t;
		logic signed [VW-1:0] p0;
		logic signed [VW-1:0] p1;
		logic signed [VW-1:0] p2;
		logic signed [VW-1:0] p3;
	} knot_item_t;

	typedef struct packed {
		logic signed [VW-1:0] value;
		logic                 ovf;
	} spline_out_t;

	typedef struct packed {
		knot_item_t  item;
		logic        typed;
		spline_out_t want;
	} vector_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [TF:0]          t_param = '0;
	logic signed [VW-1:0] ctrl_before = '0;
	logic signed [VW-1:0] ctrl_start = '0;
	logic signed [VW-1:0] ctrl_end = '0;
	logic signed [VW-1:0] ctrl_after = '0;
	logic                 done;
	logic signed [VW-1:0] interp_value;
	logic                 overflow;

	logic        row_typed = 1'b0;
	spline_out_t row_want = '0;

	spline_out_t expected_values[$];
	int          error_count = 0;
	int          cycle_count = 0;
	int          send_idle_pct = 0;

	catmull_rom_interpolator DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.t_param     (t_param),
		.ctrl_before (ctrl_before),
		.ctrl_start  (ctrl_start),
		.ctrl_end    (ctrl_end),
		.ctrl_after  (ctrl_after),
		.done        (done),
		.interp_value(interp_value),
		.overflow    (overflow)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic spline_out_t predict_spline(input knot_item_t it);
		logic signed [AW-1:0] one_q, tc, t2, t3, w0, w1, w2, w3, acc;
		spline_out_t r;
		one_q = AW'(T_ONE);
		tc = (it.t > T_ONE) ? one_q : AW'(it.t);
		t2 = (tc * tc + (one_q >>> 1)) >>> TF;
		t3 = (t2 * tc + (one_q >>> 1)) >>> TF;
		w0 = -t3 + 2 * t2 - tc;
		w1 = 3 * t3 - 5 * t2 + 2 * one_q;
		w2 = -3 * t3 + 4 * t2 + tc;
		w3 = t3 - t2;
		acc = $signed(it.p0) * w0 + $signed(it.p1) * w1 + $signed(it.p2) * w2
			+ $signed(it.p3) * w3;
		acc = (acc + one_q) >>> (TF + 1);
		r.ovf = 1'b1;
		if (acc > V_MAX) begin
			r.value = V_MAX;
		end else if (acc < V_MIN) begin
			r.value = V_MIN;
		end else begin
			r.value = acc[VW-1:0];
			r.ovf = 1'b0;
		end
		return r;
	endfunction

	function automatic logic signed [VW-1:0] random_ctrl(input ctrl_mode_t mode);
		logic signed [VW-1:0] v;
		case (mode)
			CTRL_SMALL: begin
				v = VW'($urandom_range(0, 1 << 21)) - (VW'(1) << 20);
			end
			CTRL_FULL: begin
				v = VW'($urandom);
			end
			CTRL_EXTREME: begin
				case ($urandom_range(5))
					0: v = V_MAX;
					1: v = V_MIN;
					2: v = '0;
					3: v = '1;
					4: v = Q_ONE;
					default: v = -Q_ONE;
				endcase
			end
			default: begin
				if ($urandom_range(1))
					v = V_MAX - VW'($urandom_range(0, 1 << 18));
				else
					v = V_MIN + VW'($urandom_range(0, 1 << 18));
			end
		endcase
		return v;
	endfunction

	function automatic knot_item_t random_knots();
		knot_item_t it;
		ctrl_mode_t mode;
		int r;
		mode = ctrl_mode_t'($urandom_range(3));
		r = $urandom_range(99);
		if (r < 10)
			it.t = $urandom_range(1) ? T_ONE : '0;
		else if (r < 25)
			it.t = (TF+1)'($urandom_range(0, (1 << (TF + 1)) - 1));
		else
			it.t = (TF+1)'($urandom_range(0, 1 << TF));
		it.p0 = random_ctrl(($urandom_range(3) == 0) ? ctrl_mode_t'($urandom_range(3)) : mode);
		it.p1 = random_ctrl(($urandom_range(3) == 0) ? ctrl_mode_t'($urandom_range(3)) : mode);
		it.p2 = random_ctrl(($urandom_range(3) == 0) ? ctrl_mode_t'($urandom_range(3)) : mode);
		it.p3 = random_ctrl(($urandom_range(3) == 0) ? ctrl_mode_t'($urandom_range(3)) : mode);
		return it;
	endfunction

	function automatic vector_row_t make_row(input logic [TF:0] t,
			input logic [VW-1:0] p0, input logic [VW-1:0] p1,
			input logic [VW-1:0] p2, input logic [VW-1:0] p3,
			input logic typed, input logic [VW-1:0] value, input logic ovf);
		vector_row_t row;
		row.item = '{t: t, p0: p0, p1: p1, p2: p2, p3: p3};
		row.typed = typed;
		row.want = '{value: value, ovf: ovf};
		return row;
	endfunction

	task automatic report_error(input string what, input logic [VW-1:0] got,
			input logic [VW-1:0] want);
		error_count++;
		if (error_count <= PRINT_LIMIT)
			$display("%0t ERROR %s: got %h, expected %h", $time, what, got, want);
	endtask

	task automatic send_knots(input knot_item_t it, input logic typed, input spline_out_t want);
		if ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		start <= 1'b1;
		t_param <= it.t;
		ctrl_before <= it.p0;
		ctrl_start <= it.p1;
		ctrl_end <= it.p2;
		ctrl_after <= it.p3;
		row_typed <= typed;
		row_want <= want;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// check result, then log the transaction accepted at this edge
	always @(posedge clk) begin
		spline_out_t want;
		knot_item_t seen;
		if (arst_n) begin
			if (done !== 1'b0) begin
				if (expected_values.size() == 0) begin
					report_error("result with nothing outstanding", interp_value, '0);
				end else begin
					want = expected_values.pop_front();
					if (interp_value !== want.value)
						report_error("interp_value", interp_value, want.value);
					if (overflow !== want.ovf)
						report_error("overflow", VW'(overflow), VW'(want.ovf));
				end
			end
			if (start && busy === 1'b0) begin
				seen = '{t: t_param, p0: ctrl_before, p1: ctrl_start, p2: ctrl_end,
					p3: ctrl_after};
				expected_values.push_back(row_typed ? row_want : predict_spline(seen));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("catmull_rom_interpolator: mismatch");
			$finish;
		end
	end

	initial begin
		vector_row_t directed[$];
		int phase;
		directed.push_back(make_row('0, '0, '0, '0, '0, 1'b1, '0, 1'b0));
		directed.push_back(make_row('0, V_MIN, Q_ONE, V_MAX, V_MIN, 1'b1, Q_ONE, 1'b0));
		directed.push_back(make_row(T_ONE, V_MAX, V_MIN, 32'hFFFF8000, V_MAX,
			1'b1, 32'hFFFF8000, 1'b0));
		directed.push_back(make_row(17'h1FFFF, 32'hAAAAAAAA, 32'h55555555, 32'h12345678, '0,
			1'b1, 32'h12345678, 1'b0));
		directed.push_back(make_row(17'h10001, 32'h55555555, 32'hAAAAAAAA, 32'hDEADBEEF,
			32'h0F0F0F0F, 1'b1, 32'hDEADBEEF, 1'b0));
		directed.push_back(make_row(17'h08000, V_MAX, V_MAX, V_MAX, V_MAX, 1'b1, V_MAX, 1'b0));
		directed.push_back(make_row(17'h08000, V_MIN, V_MIN, V_MIN, V_MIN, 1'b1, V_MIN, 1'b0));
		directed.push_back(make_row(17'h04000, '1, '1, '1, '1, 1'b1, '1, 1'b0));
		directed.push_back(make_row(17'h08000, V_MIN, V_MAX, V_MAX, V_MIN, 1'b1, V_MAX, 1'b1));
		directed.push_back(make_row(17'h08000, V_MAX, V_MIN, V_MIN, V_MAX, 1'b1, V_MIN, 1'b1));
		directed.push_back(make_row(17'h00001, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, 4 * Q_ONE,
			1'b0, '0, 1'b0));
		directed.push_back(make_row(17'h0FFFF, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, 4 * Q_ONE,
			1'b0, '0, 1'b0));
		directed.push_back(make_row(17'h08000, '0, Q_ONE, 2 * Q_ONE, 3 * Q_ONE,
			1'b0, '0, 1'b0));
		directed.push_back(make_row(17'h0AAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555,
			32'hAAAAAAAA, 1'b0, '0, 1'b0));
		directed.push_back(make_row(17'h05555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA,
			32'h55555555, 1'b0, '0, 1'b0));
		directed.push_back(make_row(17'h00001, V_MAX, V_MIN, V_MAX, V_MIN, 1'b0, '0, 1'b0));
		directed.push_back(make_row(17'h0C000, V_MAX, V_MAX, V_MIN, V_MIN, 1'b0, '0, 1'b0));
		directed.push_back(make_row(17'h02000, 32'h7FFF0000, 32'h7FFF8000, V_MAX, V_MAX,
			1'b0, '0, 1'b0));
		directed.push_back(make_row(17'h0E000, 32'h80010000, V_MIN, 32'h80008000, V_MIN,
			1'b0, '0, 1'b0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 13;
		foreach (directed[i])
			send_knots(directed[i].item, directed[i].typed, directed[i].want);

		for (phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 68 : 0;
			repeat (RANDOM_PER_PHASE)
				send_knots(random_knots(), 1'b0, '0);
			if (phase == 0) begin
				// hold off until the pipeline drains
				start <= 1'b0;
				while (expected_values.size() != 0) @(posedge clk);
			end
		end

		start <= 1'b0;
		while (expected_values.size() != 0) @(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
		if (error_count == 0 && expected_values.size() == 0)
			$display("catmull_rom_interpolator: match");
		else
			$display("catmull_rom_interpolator: mismatch");
		$finish;
	end

endmodule
